/* design/lzlms_pkg.sv */
// ============================================================================
// lzlms_pkg
// Shared types and constants of the longest match search unit.
// ============================================================================
`default_nettype none

package lzlms_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF  = 8192;
  localparam int unsigned MIN_MATCH_DEF     = 3;
  localparam int unsigned LOOKAHEAD_MAX_DEF = 273;

  localparam int unsigned POS_W  = 13;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned LIM_W  = 9;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0] match_length;
    logic [POS_W-1:0] match_position;
  } result_t;

endpackage

`default_nettype wire

/* design/lzlms_req_if.sv */
// ============================================================================
// lzlms_req_if
// Request channel: one byte write or one search per request.
// ============================================================================
`default_nettype none

interface lzlms_req_if;
  import lzlms_pkg::*;

  logic                valid;
  logic                ready;
  func_t               func;
  logic [POS_W-1:0]    write_address;
  logic [BYTE_W-1:0]   write_byte;
  logic [POS_W-1:0]    window_start;
  logic [POS_W-1:0]    current_offset;
  logic [LIM_W-1:0]    lookahead_limit;

  modport source (
    output valid, func, write_address, write_byte, window_start, current_offset,
           lookahead_limit,
    input  ready
  );

  modport sink (
    input  valid, func, write_address, write_byte, window_start, current_offset,
           lookahead_limit,
    output ready
  );

endinterface

`default_nettype wire

/* design/lzlms_rsp_if.sv */
// ============================================================================
// lzlms_rsp_if
// Result channel: one match length and position per search.
// ============================================================================
`default_nettype none

interface lzlms_rsp_if;
  import lzlms_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] match_length;
  logic [POS_W-1:0] match_position;

  modport source (
    output valid, match_length, match_position,
    input  ready
  );

  modport sink (
    input  valid, match_length, match_position,
    output ready
  );

endinterface

`default_nettype wire

/* design/lzlms_ram.sv */
// ============================================================================
// lzlms_ram
// Generic RAM with one write port and two registered read ports.
// ============================================================================
`default_nettype none

module lzlms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* design/lzlms_engine.sv */
// ============================================================================
// lzlms_engine
// Sequencer for byte writes and candidate scans over the window buffer.
// ============================================================================
`default_nettype none

module lzlms_engine #(
  parameter int unsigned BUFFER_DEPTH  = lzlms_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned MIN_MATCH     = lzlms_pkg::MIN_MATCH_DEF,
  parameter int unsigned LOOKAHEAD_MAX = lzlms_pkg::LOOKAHEAD_MAX_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  lzlms_req_if.sink                                  req,
  output logic                                       ram_we,
  output logic      [$clog2(BUFFER_DEPTH)-1:0]       ram_waddr,
  output logic      [lzlms_pkg::BYTE_W-1:0]          ram_wdata,
  output logic                                       ram_re,
  output logic      [$clog2(BUFFER_DEPTH)-1:0]       ram_raddr_a,
  output logic      [$clog2(BUFFER_DEPTH)-1:0]       ram_raddr_b,
  input  wire logic [lzlms_pkg::BYTE_W-1:0]          ram_rdata_a,
  input  wire logic [lzlms_pkg::BYTE_W-1:0]          ram_rdata_b,
  output logic                                       result_load,
  output lzlms_pkg::result_t                         result,
  input  wire logic                                  out_free
);

  import lzlms_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned RW = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int unsigned LW = $clog2(LOOKAHEAD_MAX + 1);
  localparam logic [RW-1:0] DEPTH_R = RW'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(BUFFER_DEPTH - 1);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == LAST_A) ? '0 : a + 1'b1;
  endfunction

  state_t state, state_next;

  func_t             func_r;
  logic [RW-1:0]     wa;
  logic [BYTE_W-1:0] wb;
  logic [RW-1:0]     pw;
  logic [RW-1:0]     cw;
  logic [POS_W-1:0]  p;
  logic [POS_W-1:0]  cur;
  logic [LW-1:0]     cap;
  logic [AW-1:0]     ca;
  logic [AW-1:0]     ua;
  logic [LW-1:0]     k;
  logic              rd_vld;
  logic [LW-1:0]     best;
  logic [POS_W-1:0]  best_pos;

  logic [LW-1:0]     cap_in;
  logic              reduced;
  logic              byte_eq;
  logic              mismatch;
  logic [LW-1:0]     kn;
  logic              cand_done;
  logic              better;
  logic [POS_W-1:0]  p_inc;
  logic              scan_stop;
  logic              short_match;

  assign cap_in = (32'(req.lookahead_limit) > 32'(LOOKAHEAD_MAX)) ?
                  LW'(LOOKAHEAD_MAX) : LW'(req.lookahead_limit);

  assign reduced   = (wa < DEPTH_R) && (pw < DEPTH_R) && (cw < DEPTH_R);
  assign byte_eq   = (ram_rdata_a == ram_rdata_b);
  assign mismatch  = rd_vld && !byte_eq;
  assign kn        = (rd_vld && byte_eq) ? k + 1'b1 : k;
  assign cand_done = mismatch || (kn == cap);
  assign better    = (kn > best);
  assign p_inc     = p + 1'b1;
  assign scan_stop = (better && (kn == cap)) || (p_inc >= cur);
  assign short_match = (32'(best) < 32'(MIN_MATCH));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (reduced) begin
          if (func_r == FUNC_WRITE) begin
            state_next = ST_IDLE;
          end else if (p < cur) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (cand_done && scan_stop) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    result_load = 1'b0;
    unique case (state)
      ST_IDLE:   req.ready   = 1'b1;
      ST_REDUCE: ram_we      = reduced && (func_r == FUNC_WRITE);
      ST_SCAN:   ram_re      = !cand_done;
      ST_DONE:   result_load = out_free;
      default: ;
    endcase
  end

  assign ram_waddr   = wa[AW-1:0];
  assign ram_wdata   = wb;
  assign ram_raddr_a = ca;
  assign ram_raddr_b = ua;

  assign result.match_length   = short_match ? '0 : LEN_W'(best);
  assign result.match_position = short_match ? '0 : best_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          rd_vld <= 1'b0;
        end
        ST_REDUCE: begin
          rd_vld <= 1'b0;
        end
        ST_SCAN: begin
          rd_vld <= !cand_done;
        end
        ST_DONE: begin
          rd_vld <= 1'b0;
        end
        default: rd_vld <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          func_r <= req.func;
          wa     <= RW'(req.write_address);
          wb     <= req.write_byte;
          pw     <= RW'(req.window_start);
          cw     <= RW'(req.current_offset);
          p      <= req.window_start;
          cur    <= req.current_offset;
          cap    <= cap_in;
        end
      end
      ST_REDUCE: begin
        if (wa >= DEPTH_R) begin
          wa <= wa - DEPTH_R;
        end
        if (pw >= DEPTH_R) begin
          pw <= pw - DEPTH_R;
        end
        if (cw >= DEPTH_R) begin
          cw <= cw - DEPTH_R;
        end
        ca       <= pw[AW-1:0];
        ua       <= cw[AW-1:0];
        k        <= '0;
        best     <= '0;
        best_pos <= '0;
      end
      ST_SCAN: begin
        if (cand_done) begin
          if (better) begin
            best     <= kn;
            best_pos <= p;
          end
          p  <= p_inc;
          pw <= RW'(wrap_inc(pw[AW-1:0]));
          ca <= wrap_inc(pw[AW-1:0]);
          ua <= cw[AW-1:0];
          k  <= '0;
        end else begin
          ca <= wrap_inc(ca);
          ua <= wrap_inc(ua);
          k  <= kn;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/lzlms_out_stage.sv */
// ============================================================================
// lzlms_out_stage
// Output register that holds one search result until it is taken.
// ============================================================================
`default_nettype none

module lzlms_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire lzlms_pkg::result_t  result,
  output logic                     free,
  lzlms_rsp_if.source              rsp
);

  import lzlms_pkg::*;

  logic    valid;
  logic    valid_next;
  result_t hold;

  assign free = !valid || rsp.ready;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (rsp.ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= result;
    end
  end

  assign rsp.valid          = valid;
  assign rsp.match_length   = hold.match_length;
  assign rsp.match_position = hold.match_position;

endmodule

`default_nettype wire

/* design/lz_longest_match_search_unit.sv */
// ============================================================================
// lz_longest_match_search_unit
// LZ77 longest match finder over a byte window buffer held in one RAM.
// ============================================================================
// A request on req either writes one byte into the window buffer or runs a
// search. A write gives no result; after the request is taken, its address is
// brought into the buffer range by repeated subtraction of the buffer length,
// the byte is written and the unit returns to idle.
// A search scans every candidate position from window_start up to, but not
// including, current_offset, comparing two buffer bytes per cycle through the
// two read ports of the window RAM. Each candidate runs until a byte mismatch
// or until its run reaches the lookahead cap; reaching a nonzero cap also ends
// the scan.
// The result goes into an output register on rsp; a new request is taken as
// soon as it is loaded, so a stalled receiver holds up the next search only
// when a second result is ready before the first one is taken.
// Reset clears the control state and the output valid. The buffer content is
// undefined until written and must be filled before it is searched.
// ============================================================================
`default_nettype none

module lz_longest_match_search_unit #(
  parameter int unsigned BUFFER_DEPTH  = lzlms_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned MIN_MATCH     = lzlms_pkg::MIN_MATCH_DEF,
  parameter int unsigned LOOKAHEAD_MAX = lzlms_pkg::LOOKAHEAD_MAX_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lzlms_req_if.sink   req,
  lzlms_rsp_if.source rsp
);

  import lzlms_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr_a;
  logic [AW-1:0]     ram_raddr_b;
  logic [BYTE_W-1:0] ram_rdata_a;
  logic [BYTE_W-1:0] ram_rdata_b;
  logic              result_load;
  result_t           result;
  logic              out_free;

  lzlms_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_window (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  lzlms_engine #(
    .BUFFER_DEPTH  (BUFFER_DEPTH),
    .MIN_MATCH     (MIN_MATCH),
    .LOOKAHEAD_MAX (LOOKAHEAD_MAX)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b),
    .result_load (result_load),
    .result      (result),
    .out_free    (out_free)
  );

  lzlms_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (result_load),
    .result (result),
    .free   (out_free),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire
